FILE: hw/rtl/tsg_pkg.sv
// Shared types, constants and the quarter-wave sine table of the turtle segment generator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package tsg_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int MAX_NODES   = 256;

    localparam int SP_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int FILL_W  = $clog2(STACK_DEPTH + 1);
    localparam int NADDR_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NODE_W  = $clog2(MAX_NODES + 1);

    localparam int FQ_DEPTH = 4;
    localparam int FQ_PW    = $clog2(FQ_DEPTH);
    localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    localparam int PADDR_W = 5;

    localparam logic signed [31:0] START_X_RST       = 32'sd26214400;
    localparam logic signed [31:0] START_Y_RST       = 32'sd38666240;
    localparam logic [15:0]        START_HEADING_RST = 16'd49152;
    localparam logic [15:0]        STEP_LENGTH_RST   = 16'd2560;
    localparam logic [15:0]        TURN_STEP_RST     = 16'd4551;
    localparam logic [8:0]         NODE_COUNT_RST    = 9'd1;

    localparam logic [2:0] REG_START_X       = 3'd0;
    localparam logic [2:0] REG_START_Y       = 3'd1;
    localparam logic [2:0] REG_START_HEADING = 3'd2;
    localparam logic [2:0] REG_STEP_LENGTH   = 3'd3;
    localparam logic [2:0] REG_TURN_STEP     = 3'd4;
    localparam logic [2:0] REG_NODE_COUNT    = 3'd5;

    localparam logic [1:0] CMD_SYMBOL  = 2'd0;
    localparam logic [1:0] CMD_NODE_WR = 2'd1;
    localparam logic [1:0] CMD_START   = 2'd2;

    localparam logic [7:0] SYM_FWD   = 8'h46;
    localparam logic [7:0] SYM_LEFT  = 8'h2B;
    localparam logic [7:0] SYM_RIGHT = 8'h2D;
    localparam logic [7:0] SYM_PUSH  = 8'h5B;
    localparam logic [7:0] SYM_POP   = 8'h5D;

    localparam logic [15:0] QUARTER_TURN = 16'h4000;

    typedef enum logic [2:0] {
        K_NONE,
        K_NODE_WR,
        K_START,
        K_FWD,
        K_LEFT,
        K_RIGHT,
        K_PUSH,
        K_POP
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  node_addr;
        logic [15:0] node_angle;
    } t_op;

    typedef struct packed {
        logic               wr;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic [15:0]        start_heading;
        logic [15:0]        step_length;
        logic [15:0]        turn_step;
        logic [8:0]         node_count;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_SEG  = 2'd0,
        ST_PAST = 2'd1,
        ST_OVF  = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [31:0] seg_start_x;
        logic signed [31:0] seg_start_y;
        logic signed [31:0] seg_end_x;
        logic signed [31:0] seg_end_y;
        logic [8:0]         branch_index;
        t_status            status;
    } t_res;

    typedef enum logic [1:0] {
        BS_RUN,
        BS_MOVE,
        BS_TABLE,
        BS_POP
    } t_bstate;

    // sin(k*pi/32) * 32768 for k = 0..16; indexes past the quarter hold the peak.
    function automatic logic [15:0] quarter_sine(input logic [4:0] idx);
        logic [15:0] v;
        case (idx)
            5'd0:    v = 16'd0;
            5'd1:    v = 16'd3212;
            5'd2:    v = 16'd6393;
            5'd3:    v = 16'd9512;
            5'd4:    v = 16'd12540;
            5'd5:    v = 16'd15447;
            5'd6:    v = 16'd18205;
            5'd7:    v = 16'd20788;
            5'd8:    v = 16'd23170;
            5'd9:    v = 16'd25330;
            5'd10:   v = 16'd27246;
            5'd11:   v = 16'd28899;
            5'd12:   v = 16'd30274;
            5'd13:   v = 16'd31357;
            5'd14:   v = 16'd32138;
            5'd15:   v = 16'd32610;
            default: v = 16'd32768;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/tsg_cfg.sv
// Configuration register file with an APB-style slave port.
// Depends on tsg_pkg for register indexes, reset values and the t_cfg struct.
`timescale 1ns / 1ps

module tsg_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tsg_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output tsg_pkg::t_cfg                o_cfg
);
    import tsg_pkg::*;

    logic signed [31:0] r_start_x;
    logic signed [31:0] r_start_y;
    logic [15:0]        r_start_heading;
    logic [15:0]        r_step_length;
    logic [15:0]        r_turn_step;
    logic [8:0]         r_node_count;
    logic               wr;
    logic [2:0]         idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x       <= START_X_RST;
            r_start_y       <= START_Y_RST;
            r_start_heading <= START_HEADING_RST;
            r_step_length   <= STEP_LENGTH_RST;
            r_turn_step     <= TURN_STEP_RST;
            r_node_count    <= NODE_COUNT_RST;
        end else if (wr) begin
            case (idx)
                REG_START_X:       r_start_x       <= pwdata;
                REG_START_Y:       r_start_y       <= pwdata;
                REG_START_HEADING: r_start_heading <= pwdata[15:0];
                REG_STEP_LENGTH:   r_step_length   <= pwdata[15:0];
                REG_TURN_STEP:     r_turn_step     <= pwdata[15:0];
                REG_NODE_COUNT:    r_node_count    <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_START_X:       prdata = r_start_x;
            REG_START_Y:       prdata = r_start_y;
            REG_START_HEADING: prdata = {16'd0, r_start_heading};
            REG_STEP_LENGTH:   prdata = {16'd0, r_step_length};
            REG_TURN_STEP:     prdata = {16'd0, r_turn_step};
            REG_NODE_COUNT:    prdata = {23'd0, r_node_count};
            default:           prdata = 32'd0;
        endcase
    end

    assign o_cfg.wr            = wr;
    assign o_cfg.start_x       = r_start_x;
    assign o_cfg.start_y       = r_start_y;
    assign o_cfg.start_heading = r_start_heading;
    assign o_cfg.step_length   = r_step_length;
    assign o_cfg.turn_step     = r_turn_step;
    assign o_cfg.node_count    = r_node_count;

endmodule

FILE: hw/rtl/tsg_front.sv
// Front end: decodes each accepted beat into an operation and queues those that do something for the back end.
// Depends on tsg_pkg for command and symbol codes and the t_op struct.
`timescale 1ns / 1ps

module tsg_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    output logic         o_full,
    input  logic [1:0]   i_cmd,
    input  logic [7:0]   i_symbol,
    input  logic [7:0]   i_node_addr,
    input  logic [15:0]  i_node_angle,
    output logic         o_op_valid,
    output tsg_pkg::t_op o_op,
    input  logic         i_op_take
);
    import tsg_pkg::*;

    t_op              r_q [FQ_DEPTH];
    logic [FQ_PW-1:0] r_wp;
    logic [FQ_PW-1:0] r_rp;
    logic [FQ_CW-1:0] r_cnt;
    t_kind            kind;
    logic             enq;

    always_comb begin
        kind = K_NONE;
        case (i_cmd)
            CMD_SYMBOL: begin
                case (i_symbol)
                    SYM_FWD:   kind = K_FWD;
                    SYM_LEFT:  kind = K_LEFT;
                    SYM_RIGHT: kind = K_RIGHT;
                    SYM_PUSH:  kind = K_PUSH;
                    SYM_POP:   kind = K_POP;
                    default:   kind = K_NONE;
                endcase
            end
            CMD_NODE_WR: kind = K_NODE_WR;
            CMD_START:   kind = K_START;
            default:     kind = K_NONE;
        endcase
    end

    assign o_full     = (r_cnt == FQ_CW'(FQ_DEPTH));
    assign o_op_valid = (r_cnt != '0);
    assign o_op       = r_q[r_rp];
    // Beats that do nothing are accepted and dropped here.
    assign enq        = i_push && !o_full && (kind != K_NONE);

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wp].kind       <= kind;
            r_q[r_wp].node_addr  <= i_node_addr;
            r_q[r_wp].node_angle <= i_node_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (enq) begin
                r_wp <= (r_wp == FQ_PW'(FQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_op_take) begin
                r_rp <= (r_rp == FQ_PW'(FQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({enq, i_op_take})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: hw/rtl/tsg_move.sv
// Three-stage move unit: interpolated sine and cosine of a heading, scaled by the step length.
// Depends on tsg_pkg for the quarter-wave table.
`timescale 1ns / 1ps

module tsg_move (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [15:0]        i_heading,
    input  logic [15:0]        i_step_len,
    output logic               o_done,
    output logic signed [31:0] o_dx,
    output logic signed [31:0] o_dy
);
    import tsg_pkg::*;

    // Lane 0 is the x move (cosine), lane 1 the y move (sine).
    logic [15:0] s1_h    [2];
    logic [14:0] s1_r    [2];
    logic [15:0] s1_base [2];
    logic [15:0] s1_diff [2];
    logic [15:0] s2_v    [2];
    logic [31:0] s3_d    [2];

    logic        r_v1, r_v2, r_v3;
    logic [15:0] r_base [2];
    logic [25:0] r_prod [2];
    logic        r_neg1 [2];
    logic [31:0] r_mag  [2];
    logic        r_neg2 [2];
    logic [31:0] r_d    [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            s1_h[l] = (l == 0) ? i_heading + QUARTER_TURN : i_heading;
            // Odd quadrants run the quarter wave backwards.
            s1_r[l] = s1_h[l][14] ? 15'h4000 - {1'b0, s1_h[l][13:0]} : {1'b0, s1_h[l][13:0]};
            s1_base[l] = quarter_sine(s1_r[l][14:10]);
            s1_diff[l] = quarter_sine(s1_r[l][14:10] + 5'd1) - s1_base[l];
            s2_v[l] = r_base[l] + 16'((r_prod[l] + 26'd512) >> 10);
            s3_d[l] = 32'((33'(r_mag[l]) + 33'd64) >> 7);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 2; l++) begin
            r_base[l] <= s1_base[l];
            r_prod[l] <= 26'(s1_diff[l]) * 26'(s1_r[l][9:0]);
            r_neg1[l] <= s1_h[l][15];
            r_mag[l]  <= 32'(s2_v[l]) * 32'(i_step_len);
            r_neg2[l] <= r_neg1[l];
            r_d[l]    <= r_neg2[l] ? 32'd0 - s3_d[l] : s3_d[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_done = r_v3;
    assign o_dx   = r_d[0];
    assign o_dy   = r_d[1];

endmodule

FILE: hw/rtl/tsg_back.sv
// Back end: turtle state, node angle table, branch stack and result queue.
// Depends on tsg_pkg and instantiates tsg_move.
`timescale 1ns / 1ps

module tsg_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tsg_pkg::t_cfg i_cfg,
    input  logic          i_op_valid,
    input  tsg_pkg::t_op  i_op,
    output logic          o_op_take,
    input  logic          i_pop,
    output logic          o_empty,
    output tsg_pkg::t_res o_res
);
    import tsg_pkg::*;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [15:0]        h;
    } t_frame;

    t_bstate             r_state, n_state;
    logic signed [31:0]  r_pos_x, n_pos_x;
    logic signed [31:0]  r_pos_y, n_pos_y;
    logic [15:0]         r_heading, n_heading;
    logic [NODE_W-1:0]   r_bc, n_bc;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic                r_mv_valid, n_mv_valid;

    logic [15:0]         r_tbl_mem [MAX_NODES];
    logic [MAX_NODES-1:0] r_tbl_vld;
    logic [15:0]         r_tbl_q;
    logic                r_tbl_hit;
    logic                tbl_we, tbl_re;
    logic [NADDR_W-1:0]  tbl_wa, tbl_ra;
    logic [15:0]         tbl_entry;

    t_frame              r_stk_mem [STACK_DEPTH];
    t_frame              r_stk_q;
    logic                stk_we, stk_re;
    logic [SP_W-1:0]     stk_wa, stk_ra;

    t_res                r_oq [OQ_DEPTH];
    logic [OQ_PW-1:0]    r_oq_wp, r_oq_rp;
    logic [OQ_CW-1:0]    r_oq_cnt;
    logic                em_vld;
    t_res                em_res;
    logic                oq_pop, out_full;

    logic                mv_start, mv_done;
    logic signed [31:0]  mv_dx, mv_dy;
    logic [NODE_W-1:0]   bc_inc;
    logic                stk_full, past;

    tsg_move u_move (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mv_start),
        .i_heading  (r_heading),
        .i_step_len (i_cfg.step_length),
        .o_done     (mv_done),
        .o_dx       (mv_dx),
        .o_dy       (mv_dy)
    );

    assign out_full  = (r_oq_cnt == OQ_CW'(OQ_DEPTH));
    assign o_empty   = (r_oq_cnt == '0);
    assign o_res     = r_oq[r_oq_rp];
    assign oq_pop    = i_pop && !o_empty;
    assign tbl_entry = r_tbl_hit ? r_tbl_q : 16'd0;
    assign tbl_wa    = NADDR_W'(i_op.node_addr);
    assign stk_wa    = SP_W'(r_fill);
    assign stk_ra    = SP_W'(r_fill - 1'b1);

    // The node counter saturates at the table size.
    assign bc_inc   = (32'(r_bc) < MAX_NODES) ? r_bc + 1'b1 : r_bc;
    assign past     = !((32'(bc_inc) < 32'(i_cfg.node_count)) && (32'(bc_inc) < MAX_NODES));
    assign stk_full = (32'(r_fill) >= STACK_DEPTH);

    always_comb begin
        n_state    = r_state;
        n_pos_x    = r_pos_x;
        n_pos_y    = r_pos_y;
        n_heading  = r_heading;
        n_bc       = r_bc;
        n_fill     = r_fill;
        n_mv_valid = r_mv_valid;
        o_op_take  = 1'b0;
        em_vld     = 1'b0;
        em_res     = '0;
        tbl_we     = 1'b0;
        tbl_re     = 1'b0;
        tbl_ra     = '0;
        stk_we     = 1'b0;
        stk_re     = 1'b0;
        mv_start   = 1'b0;

        case (r_state)
            BS_RUN: begin
                if (i_op_valid && !out_full) begin
                    case (i_op.kind)
                        K_NODE_WR: begin
                            o_op_take = 1'b1;
                            tbl_we    = (32'(i_op.node_addr) < MAX_NODES);
                        end
                        K_START: begin
                            o_op_take  = 1'b1;
                            n_pos_x    = i_cfg.start_x;
                            n_pos_y    = i_cfg.start_y;
                            n_bc       = '0;
                            n_fill     = '0;
                            n_heading  = i_cfg.start_heading;
                            n_mv_valid = 1'b0;
                            if (i_cfg.node_count == 9'd0) begin
                                em_vld        = 1'b1;
                                em_res.status = ST_PAST;
                            end else begin
                                tbl_re  = 1'b1;
                                n_state = BS_TABLE;
                            end
                        end
                        K_FWD: begin
                            // The move vector is cached until the heading may change or a register is written.
                            if (r_mv_valid) begin
                                o_op_take           = 1'b1;
                                em_vld              = 1'b1;
                                em_res.seg_start_x  = r_pos_x;
                                em_res.seg_start_y  = r_pos_y;
                                em_res.seg_end_x    = r_pos_x + mv_dx;
                                em_res.seg_end_y    = r_pos_y + mv_dy;
                                em_res.branch_index = 9'(r_bc);
                                em_res.status       = ST_SEG;
                                n_pos_x             = r_pos_x + mv_dx;
                                n_pos_y             = r_pos_y + mv_dy;
                            end else begin
                                mv_start = 1'b1;
                                n_state  = BS_MOVE;
                            end
                        end
                        K_LEFT: begin
                            o_op_take  = 1'b1;
                            n_heading  = r_heading + i_cfg.turn_step;
                            n_mv_valid = 1'b0;
                        end
                        K_RIGHT: begin
                            o_op_take  = 1'b1;
                            n_heading  = r_heading - i_cfg.turn_step;
                            n_mv_valid = 1'b0;
                        end
                        K_PUSH: begin
                            o_op_take = 1'b1;
                            if (!stk_full) begin
                                stk_we = 1'b1;
                                n_fill = r_fill + 1'b1;
                            end
                            n_bc = bc_inc;
                            if (stk_full || past) begin
                                em_vld              = 1'b1;
                                em_res.branch_index = 9'(bc_inc);
                                em_res.status       = stk_full ? ST_OVF : ST_PAST;
                            end
                            if (!past) begin
                                tbl_re  = 1'b1;
                                tbl_ra  = NADDR_W'(bc_inc);
                                n_state = BS_TABLE;
                            end
                        end
                        K_POP: begin
                            o_op_take = 1'b1;
                            if (r_fill != '0) begin
                                n_fill  = r_fill - 1'b1;
                                stk_re  = 1'b1;
                                n_state = BS_POP;
                            end
                        end
                        default: o_op_take = 1'b1;
                    endcase
                end
            end
            BS_MOVE: begin
                if (mv_done) begin
                    n_mv_valid = 1'b1;
                    n_state    = BS_RUN;
                end
            end
            BS_TABLE: begin
                n_heading  = r_heading + tbl_entry;
                n_mv_valid = 1'b0;
                n_state    = BS_RUN;
            end
            BS_POP: begin
                n_pos_x    = r_stk_q.x;
                n_pos_y    = r_stk_q.y;
                n_heading  = r_stk_q.h;
                n_mv_valid = 1'b0;
                n_state    = BS_RUN;
            end
            default: n_state = BS_RUN;
        endcase

        // Any register write clears the cached move, since a new step length makes it stale.
        if (i_cfg.wr) begin
            n_mv_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BS_RUN;
            r_pos_x    <= START_X_RST;
            r_pos_y    <= START_Y_RST;
            r_heading  <= START_HEADING_RST;
            r_bc       <= '0;
            r_fill     <= '0;
            r_mv_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pos_x    <= n_pos_x;
            r_pos_y    <= n_pos_y;
            r_heading  <= n_heading;
            r_bc       <= n_bc;
            r_fill     <= n_fill;
            r_mv_valid <= n_mv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl_mem[tbl_wa] <= i_op.node_angle;
        end
        if (tbl_re) begin
            r_tbl_q   <= r_tbl_mem[tbl_ra];
            r_tbl_hit <= r_tbl_vld[tbl_ra];
        end
    end

    // Entries never written read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbl_vld <= '0;
        end else if (tbl_we) begin
            r_tbl_vld[tbl_wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk_mem[stk_wa] <= {r_pos_x, r_pos_y, r_heading};
        end
        if (stk_re) begin
            r_stk_q <= r_stk_mem[stk_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (em_vld) begin
            r_oq[r_oq_wp] <= em_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= '0;
            r_oq_rp  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (em_vld) begin
                r_oq_wp <= (r_oq_wp == OQ_PW'(OQ_DEPTH - 1)) ? '0 : r_oq_wp + 1'b1;
            end
            if (oq_pop) begin
                r_oq_rp <= (r_oq_rp == OQ_PW'(OQ_DEPTH - 1)) ? '0 : r_oq_rp + 1'b1;
            end
            case ({em_vld, oq_pop})
                2'b10:   r_oq_cnt <= r_oq_cnt + 1'b1;
                2'b01:   r_oq_cnt <= r_oq_cnt - 1'b1;
                default: r_oq_cnt <= r_oq_cnt;
            endcase
        end
    end

endmodule

FILE: hw/rtl/turtle_segment_generator.sv
// Throughput: one beat per cycle, while the result queue has room, for F with an unchanged heading,
// + and -, node writes and ignored symbols. A [ that reads the node table, a ] on a non-empty stack
// and a string start with a nonzero node count also pass through BS_TABLE or BS_POP, and the first
// F after a heading or register change waits for tsg_move.
// Reset is synchronous: queues empty, registers and pose take their defaults, node table reads zero.
`timescale 1ns / 1ps

module turtle_segment_generator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tsg_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  i_cmd,
    input  logic [7:0]                  i_symbol,
    input  logic [7:0]                  i_node_addr,
    input  logic [15:0]                 i_node_angle,
    output logic                        empty,
    input  logic                        pop,
    output logic signed [31:0]          o_seg_start_x,
    output logic signed [31:0]          o_seg_start_y,
    output logic signed [31:0]          o_seg_end_x,
    output logic signed [31:0]          o_seg_end_y,
    output logic [8:0]                  o_branch_index,
    output logic [1:0]                  o_status
);
    import tsg_pkg::*;

    t_cfg cfg;
    t_op  op;
    logic op_valid;
    logic op_take;
    t_res res;

    tsg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tsg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_cmd        (i_cmd),
        .i_symbol     (i_symbol),
        .i_node_addr  (i_node_addr),
        .i_node_angle (i_node_angle),
        .o_op_valid   (op_valid),
        .o_op         (op),
        .i_op_take    (op_take)
    );

    tsg_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_op_valid (op_valid),
        .i_op       (op),
        .o_op_take  (op_take),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_res      (res)
    );

    assign o_seg_start_x  = res.seg_start_x;
    assign o_seg_start_y  = res.seg_start_y;
    assign o_seg_end_x    = res.seg_end_x;
    assign o_seg_end_y    = res.seg_end_y;
    assign o_branch_index = res.branch_index;
    assign o_status       = res.status;

`ifndef SYNTH
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        op_take |-> op_valid)
        else $error("back end took an operation from an empty front queue");

    a_full_has_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> op_valid)
        else $error("front queue reports full but offers no operation");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");
`endif

endmodule
